### hw/rtl/rotation_matrix_to_quaternion_core_macros.svh
// assertion macros for the rotation matrix to quaternion core
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT_NOW(lbl, ck, rstn, lhs, rhs) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (lhs) |-> (rhs)) \
		else $error("rmq check failed");
`define RMQ_ASSERT_NEXT(lbl, ck, rstn, lhs, rhs) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (lhs) |=> (rhs)) \
		else $error("rmq check failed");
`else
`define RMQ_ASSERT_NOW(lbl, ck, rstn, lhs, rhs)
`define RMQ_ASSERT_NEXT(lbl, ck, rstn, lhs, rhs)
`endif
`endif

### hw/rtl/rmq_pkg.sv
// shared types, constants and step functions of the quaternion core
// no dependencies
package rmq_pkg;
	localparam int RootW     = 14;
	localparam int RadW      = 2 * RootW;
	localparam int SqRemW    = 17;
	localparam int QuoW      = 24;
	localparam int DivRemW   = 16;
	localparam int SqPerSt   = 2;
	localparam int SqStages  = RootW / SqPerSt;
	localparam int DivPerSt  = 3;
	localparam int DivStages = QuoW / DivPerSt;
	localparam int MatW      = 14;
	localparam int CompW     = 16;
	localparam int ProdW     = CompW + QuoW + 1;
	localparam int FracW     = 12;
	localparam logic [1:0] SelW = 2'd3;

	typedef struct packed {
		logic signed [CompW-1:0] n0;
		logic signed [CompW-1:0] n1;
		logic signed [CompW-1:0] n2;
		logic signed [CompW-1:0] n3;
		logic [1:0]              sel;
	} side_t;

	typedef struct packed {
		logic [RadW-1:0] rad;
		side_t           side;
	} rr_in_t;

	typedef struct packed {
		logic [RootW-1:0] root;
		logic [QuoW-1:0]  recip;
		side_t            side;
	} rr_out_t;

	typedef struct packed {
		logic [SqRemW-1:0] rem;
		logic [RootW-1:0]  root;
		logic [RadW-1:0]   rad;
	} sq_t;

	typedef struct packed {
		logic [DivRemW-1:0] rem;
		logic [QuoW-1:0]    quo;
		logic [QuoW-1:0]    dvd;
		logic [RootW-1:0]   den;
	} div_t;

	// one digit of the restoring square root
	function automatic sq_t sqrt_step(sq_t x);
		sq_t y;
		logic [SqRemW-1:0] remsh;
		logic [SqRemW-1:0] trial;
		remsh = {x.rem[SqRemW-3:0], x.rad[RadW-1 -: 2]};
		trial = {1'b0, x.root, 2'b01};
		y.rad = {x.rad[RadW-3:0], 2'b00};
		if (remsh >= trial) begin
			y.rem  = remsh - trial;
			y.root = {x.root[RootW-2:0], 1'b1};
		end else begin
			y.rem  = remsh;
			y.root = {x.root[RootW-2:0], 1'b0};
		end
		return y;
	endfunction

	// one bit of the restoring divide
	function automatic div_t div_step(div_t x);
		div_t y;
		logic [DivRemW-1:0] remsh;
		logic [DivRemW-1:0] dext;
		remsh = {x.rem[DivRemW-2:0], x.dvd[QuoW-1]};
		dext  = {{(DivRemW-RootW){1'b0}}, x.den};
		y.den = x.den;
		y.dvd = {x.dvd[QuoW-2:0], 1'b0};
		if (remsh >= dext) begin
			y.rem = remsh - dext;
			y.quo = {x.quo[QuoW-2:0], 1'b1};
		end else begin
			y.rem = remsh;
			y.quo = {x.quo[QuoW-2:0], 1'b0};
		end
		return y;
	endfunction
endpackage

### hw/rtl/rmq_recip_pipe.sv
// pipelined square root followed by the pipelined reciprocal divide
// depends on rmq_pkg
module rmq_recip_pipe
	import rmq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ce,
	input  logic    in_valid,
	input  rr_in_t  in_data,
	output logic    out_valid,
	output rr_out_t out_data
);
	sq_t   sq_in;
	sq_t   sq_s [SqStages];
	side_t sq_side_s [SqStages];
	logic [SqStages-1:0] sq_v_s;
	div_t  dv_in;
	div_t  dv_s [DivStages];
	side_t dv_side_s [DivStages];
	logic [RootW-1:0] dv_root_s [DivStages];
	logic [DivStages-1:0] dv_v_s;

	assign sq_in = '{rem: '0, root: '0, rad: in_data.rad};

	genvar g;
	for (g = 0; g < SqStages; g++) begin : g_sq
		sq_t   prev;
		side_t prev_side;
		logic  prev_v;
		sq_t   mid;
		if (g == 0) begin : g_first
			assign prev      = sq_in;
			assign prev_side = in_data.side;
			assign prev_v    = in_valid;
		end else begin : g_next
			assign prev      = sq_s[g-1];
			assign prev_side = sq_side_s[g-1];
			assign prev_v    = sq_v_s[g-1];
		end
		assign mid = sqrt_step(prev);
		always_ff @(posedge clk) begin
			if (ce) begin
				sq_s[g]      <= sqrt_step(mid);
				sq_side_s[g] <= prev_side;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[g] <= 1'b0;
			end else if (ce) begin
				sq_v_s[g] <= prev_v;
			end
		end
	end

	// dividend is the constant 2048 * 4096
	assign dv_in = '{rem: '0, quo: '0, dvd: QuoW'(1) << (QuoW - 1),
		den: sq_s[SqStages-1].root};

	for (g = 0; g < DivStages; g++) begin : g_dv
		div_t  prev;
		side_t prev_side;
		logic  prev_v;
		div_t  st1;
		div_t  st2;
		if (g == 0) begin : g_first
			assign prev      = dv_in;
			assign prev_side = sq_side_s[SqStages-1];
			assign prev_v    = sq_v_s[SqStages-1];
		end else begin : g_next
			assign prev      = dv_s[g-1];
			assign prev_side = dv_side_s[g-1];
			assign prev_v    = dv_v_s[g-1];
		end
		assign st1 = div_step(prev);
		assign st2 = div_step(st1);
		always_ff @(posedge clk) begin
			if (ce) begin
				dv_s[g]      <= div_step(st2);
				dv_side_s[g] <= prev_side;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[g] <= 1'b0;
			end else if (ce) begin
				dv_v_s[g] <= prev_v;
			end
		end
	end

	assign dv_root_s[0] = dv_s[0].den;
	for (g = 1; g < DivStages; g++) begin : g_root
		assign dv_root_s[g] = dv_s[g].den;
	end

	assign out_valid      = dv_v_s[DivStages-1];
	assign out_data.root  = dv_root_s[DivStages-1];
	// zero root gives a zero reciprocal
	assign out_data.recip = (dv_root_s[DivStages-1] == '0) ? '0 : dv_s[DivStages-1].quo;
	assign out_data.side  = dv_side_s[DivStages-1];
endmodule

### hw/rtl/rotation_matrix_to_quaternion_core.sv
// Converts one 3x3 rotation matrix in signed 2.12 to a quaternion (x,y,z,w) in 4.12.
// A new matrix may enter every clock cycle while the output is not stalled. Each result passes
// through these register stages in order: a set-up stage, the root pipeline
// (seven stages of two root bits), the reciprocal divide (eight stages of three
// quotient bits) and two product stages. A stall at the output holds the whole pipeline in place.
// Depends on rmq_pkg, rmq_recip_pipe and the assertion macro header.
`include "rotation_matrix_to_quaternion_core_macros.svh"
module rotation_matrix_to_quaternion_core
	import rmq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 (14 bits each), two zero bits
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// qx, qy, qz, qw (16 bits each)
	output logic [63:0]  m_axis_tdata
);
	logic signed [MatW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [CompW:0] tr;
	logic signed [CompW:0] arg;
	logic [1:0] axis;
	side_t side_c;
	logic ce;

	logic   v_s1;
	rr_in_t rr_s1;
	logic    rr_v;
	rr_out_t rr_o;

	logic v_s2;
	logic signed [ProdW-1:0] p_s2 [4];
	logic [1:0] sel_s2;
	logic [CompW-1:0] half_s2;

	logic v_s3;
	logic [CompW-1:0] q_s3 [4];

	assign m00 = s_axis_tdata[0*MatW +: MatW];
	assign m01 = s_axis_tdata[1*MatW +: MatW];
	assign m02 = s_axis_tdata[2*MatW +: MatW];
	assign m10 = s_axis_tdata[3*MatW +: MatW];
	assign m11 = s_axis_tdata[4*MatW +: MatW];
	assign m12 = s_axis_tdata[5*MatW +: MatW];
	assign m20 = s_axis_tdata[6*MatW +: MatW];
	assign m21 = s_axis_tdata[7*MatW +: MatW];
	assign m22 = s_axis_tdata[8*MatW +: MatW];

	assign ce            = !v_s3 || m_axis_tready;
	assign s_axis_tready = ce;

	always_comb begin
		tr = (CompW+1)'(m00) + (CompW+1)'(m11) + (CompW+1)'(m22);
		// strict compares, lower index wins a tie
		axis = 2'd0;
		if (m11 > m00) axis = 2'd1;
		if ((axis == 2'd1 && m22 > m11) || (axis == 2'd0 && m22 > m00)) axis = 2'd2;
		side_c = '0;
		if (tr > 0) begin
			arg       = tr + (CompW+1)'(4096);
			side_c.n0 = CompW'(m21) - CompW'(m12);
			side_c.n1 = CompW'(m02) - CompW'(m20);
			side_c.n2 = CompW'(m10) - CompW'(m01);
			side_c.sel = SelW;
		end else begin
			case (axis)
				2'd1: begin
					arg = (CompW+1)'(m11) - ((CompW+1)'(m22) + (CompW+1)'(m00))
						+ (CompW+1)'(4096);
					side_c.n3 = CompW'(m02) - CompW'(m20);
					side_c.n2 = CompW'(m21) + CompW'(m12);
					side_c.n0 = CompW'(m01) + CompW'(m10);
				end
				2'd2: begin
					arg = (CompW+1)'(m22) - ((CompW+1)'(m00) + (CompW+1)'(m11))
						+ (CompW+1)'(4096);
					side_c.n3 = CompW'(m10) - CompW'(m01);
					side_c.n0 = CompW'(m02) + CompW'(m20);
					side_c.n1 = CompW'(m12) + CompW'(m21);
				end
				default: begin
					arg = (CompW+1)'(m00) - ((CompW+1)'(m11) + (CompW+1)'(m22))
						+ (CompW+1)'(4096);
					side_c.n3 = CompW'(m21) - CompW'(m12);
					side_c.n1 = CompW'(m10) + CompW'(m01);
					side_c.n2 = CompW'(m20) + CompW'(m02);
				end
			endcase
			side_c.sel = axis;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// radicand is arg * 4096, zero for a non-positive argument
			rr_s1.rad  <= (arg > 0) ? {arg[RadW-FracW-1:0], {FracW{1'b0}}} : '0;
			rr_s1.side <= side_c;
		end
	end

	rmq_recip_pipe u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (v_s1),
		.in_data  (rr_s1),
		.out_valid(rr_v),
		.out_data (rr_o)
	);

	always_ff @(posedge clk) begin
		if (ce) begin
			p_s2[0] <= ProdW'(rr_o.side.n0) * $signed({1'b0, rr_o.recip});
			p_s2[1] <= ProdW'(rr_o.side.n1) * $signed({1'b0, rr_o.recip});
			p_s2[2] <= ProdW'(rr_o.side.n2) * $signed({1'b0, rr_o.recip});
			p_s2[3] <= ProdW'(rr_o.side.n3) * $signed({1'b0, rr_o.recip});
			sel_s2  <= rr_o.side.sel;
			half_s2 <= {{(CompW-RootW+1){1'b0}}, rr_o.root[RootW-1:1]};
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_out
		logic signed [ProdW-1:0] adj;
		// truncate toward zero on the shift by 4096
		assign adj = p_s2[c] + (p_s2[c][ProdW-1] ? ProdW'(4095) : ProdW'(0));
		always_ff @(posedge clk) begin
			if (ce) begin
				q_s3[c] <= (sel_s2 == 2'(c)) ? half_s2 : adj[FracW +: CompW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= rr_v;
			v_s3 <= v_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {q_s3[3], q_s3[2], q_s3[1], q_s3[0]};

	`RMQ_ASSERT_NEXT(a_req_enters, clk, arst_n, s_axis_tvalid && s_axis_tready, v_s1)
	`RMQ_ASSERT_NOW(a_zero_recip, clk, arst_n, rr_v && rr_o.root == '0, rr_o.recip == '0)
	`RMQ_ASSERT_NEXT(a_stall_holds, clk, arst_n, v_s2 && !ce, $stable(p_s2[3]) && v_s2)
endmodule

### tb/sv/tb_top.sv
// self-checking testbench for rotation_matrix_to_quaternion_core
// random and directed matrices are checked against a quaternion predictor in a scoreboard class
// depends on the core and rmq_pkg only
module tb_top;
	import rmq_pkg::*;

	typedef logic signed [MatW-1:0] elem_t;
	typedef elem_t mat_t [9];

	class quat_scoreboard;
		logic [63:0] expected_quats[$];
		int          mismatches;
		int          checked;

		function longint root12(longint a);
			longint n;
			longint r;
			longint t;
			if (a <= 0)
				return 0;
			n = a * 4096;
			r = 0;
			for (int b = 20; b >= 0; b--) begin
				t = r + (longint'(1) << b);
				if (t * t <= n)
					r = t;
			end
			return r;
		endfunction

		function logic [63:0] to_quaternion(mat_t mm);
			longint m[3][3];
			longint q[4];
			longint tr;
			longint s;
			longint r;
			int     i;
			int     j;
			int     k;
			for (int a = 0; a < 9; a++)
				m[a / 3][a % 3] = longint'(mm[a]);
			tr = m[0][0] + m[1][1] + m[2][2];
			if (tr > 0) begin
				s    = root12(tr + 4096);
				q[3] = s / 2;
				r    = (s != 0) ? 64'sd8388608 / s : 0;
				q[0] = (m[2][1] - m[1][2]) * r / 4096;
				q[1] = (m[0][2] - m[2][0]) * r / 4096;
				q[2] = (m[1][0] - m[0][1]) * r / 4096;
			end else begin
				// strict compares, so ties keep the lower axis
				i = 0;
				if (m[1][1] > m[0][0])
					i = 1;
				if (m[2][2] > m[i][i])
					i = 2;
				j    = (i + 1) % 3;
				k    = (j + 1) % 3;
				s    = root12(m[i][i] - (m[j][j] + m[k][k]) + 4096);
				q[i] = s / 2;
				r    = (s != 0) ? 64'sd8388608 / s : 0;
				q[3] = (m[k][j] - m[j][k]) * r / 4096;
				q[j] = (m[j][i] + m[i][j]) * r / 4096;
				q[k] = (m[k][i] + m[i][k]) * r / 4096;
			end
			return {q[3][15:0], q[2][15:0], q[1][15:0], q[0][15:0]};
		endfunction

		function void note_request(mat_t mm);
			expected_quats.push_back(to_quaternion(mm));
		endfunction

		function void check_result(logic [63:0] got);
			logic [63:0] exp_q;
			string       names[4];
			names = '{"qx", "qy", "qz", "qw"};
			checked++;
			if (expected_quats.size() == 0) begin
				$error("result 0x%h arrived with nothing expected", got);
				mismatches++;
				return;
			end
			exp_q = expected_quats.pop_front();
			for (int c = 0; c < 4; c++)
				if (exp_q[16*c +: 16] !== got[16*c +: 16]) begin
					$error("%s: expected %0d, got %0d", names[c],
						$signed(exp_q[16*c +: 16]), $signed(got[16*c +: 16]));
					mismatches++;
				end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;

	quat_scoreboard sb;
	int             tx_gap_pct;
	int             rx_stall_pct;
	bit             long_hold_req;
	int             stall_left;
	int             sent;

	rotation_matrix_to_quaternion_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

	function automatic elem_t rnd_elem();
		if ($urandom_range(99) < 75)
			return elem_t'(int'($urandom_range(8192)) - 4096);
		return elem_t'($urandom());
	endfunction

	task automatic send_matrix(mat_t mm);
		logic [127:0] d;
		d = '0;
		for (int a = 0; a < 9; a++)
			d[MatW*a +: MatW] = mm[a];
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(mm);
		sent++;
		if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_diag(int d0, int d1, int d2, int off);
		mat_t mm;
		foreach (mm[a])
			mm[a] = elem_t'(off);
		mm[0] = elem_t'(d0);
		mm[4] = elem_t'(d1);
		mm[8] = elem_t'(d2);
		send_matrix(mm);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_quats.size() != 0)
			@(posedge clk);
	endtask

	// result side: random back-pressure plus a single long hold
	initial begin
		m_axis_tready = 1'b0;
		stall_left    = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 0;
				stall_left    = 150;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
			end
		end
	end

	initial begin
		mat_t mm;
		sb            = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		tx_gap_pct    = 0;
		rx_stall_pct  = 0;
		long_hold_req = 0;
		sent          = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, half turns about each axis, diagonal ties, extremes
		send_diag(4096, 4096, 4096, 0);
		send_diag(4096, -4096, -4096, 0);
		send_diag(-4096, 4096, -4096, 0);
		send_diag(-4096, -4096, 4096, 0);
		send_diag(0, 0, 0, 0);
		send_diag(-4096, -4096, -4096, 0);
		send_diag(-2048, -2048, -2048, 1000);
		send_diag(4096, 4096, -8192, 300);
		send_diag(8191, 8191, 8191, 0);
		send_diag(8191, 8191, 8191, -8192);
		send_diag(-8192, -8192, -8192, 8191);
		send_diag(-8192, -8192, -8192, -8192);
		send_diag(1, 1, -2, 4096);
		send_diag(-1, 0, 0, -4096);
		send_diag(-100, -100, 50, 2000);
		// sign-opposed off-diagonals to push the off-diagonal sums past 14 bits
		foreach (mm[a])
			mm[a] = (a % 2) ? elem_t'(8191) : elem_t'(-8192);
		mm[0] = elem_t'(1);
		mm[4] = elem_t'(-1);
		mm[8] = elem_t'(0);
		send_matrix(mm);
		foreach (mm[a])
			mm[a] = (a % 2) ? elem_t'(-8192) : elem_t'(8191);
		mm[0] = elem_t'(1);
		mm[4] = elem_t'(1);
		mm[8] = elem_t'(-1);
		send_matrix(mm);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 45; rx_stall_pct = 0;  end
				2: begin tx_gap_pct = 0;  rx_stall_pct = 45; end
				default: begin tx_gap_pct = 7; rx_stall_pct = 7; end
			endcase
			for (int n = 0; n < 235; n++) begin
				if (phase == 0 && n == 60)
					long_hold_req = 1;
				foreach (mm[a])
					mm[a] = rnd_elem();
				// bias the diagonal so both trace branches and every axis come up
				if ($urandom_range(3) == 0)
					mm[$urandom_range(2) * 4] = elem_t'($urandom_range(4096));
				send_matrix(mm);
			end
			// sender waits for the pipeline to empty between phases
			wait_drained();
		end

		repeat (40) @(posedge clk);
		$display("covered %0d matrices over four handshake phases with a long output hold",
			sent);
		$display("%0d results checked, %0d field mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_quats.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
